>>> hw/rtl/tachometer_rpm_averager_unit_defines.svh
// ----------------------------------------------------------------------------
// Tachometer rpm averager: assertion macros
// Shared property wrappers for the checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef TACHOMETER_RPM_AVERAGER_UNIT_DEFINES_SVH
`define TACHOMETER_RPM_AVERAGER_UNIT_DEFINES_SVH

// Check a property outside reset
`define TACHO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define TACHO_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/tacho_pkg.sv
// ----------------------------------------------------------------------------
// Tachometer rpm averager package
// Widths, constants, register indexes and shared types of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tacho_pkg;

	localparam int SAMPLES_DEF = 5;
	localparam int IV_W        = 18;
	localparam int MULT_W      = 4;
	localparam int TIME_W      = 32;
	localparam int RPM_W       = 28;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int DIV_W       = 25;
	localparam int Q_DEPTH     = 2;

	localparam logic [DIV_W-1:0]  RPM_NUMER = 25'd30000000;
	localparam logic [RPM_W-1:0]  RPM_MAX   = 28'd240000000;

	localparam logic [MULT_W-1:0] MULT_RST    = 4'd1;
	localparam logic [IV_W-1:0]   MIN_IV_RST  = 18'd1050;
	localparam logic [IV_W-1:0]   MAX_IV_RST  = 18'd200000;
	localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd1000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MULT,
		REG_MIN_IV,
		REG_MAX_IV,
		REG_TIMEOUT
	} reg_idx_t;

	typedef struct packed {
		logic [MULT_W-1:0] mult;
		logic [IV_W-1:0]   min_iv;
		logic [IV_W-1:0]   max_iv;
		logic [TIME_W-1:0] timeout;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_CALC,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t       kind;
		logic [IV_W-1:0] iv;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_AVG_GO,
		B_AVG_WAIT,
		B_RPM_GO,
		B_RPM_WAIT,
		B_SAT
	} back_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/tachometer_rpm_averager_unit.sv
// Pulse-period tachometer with a moving average. Each item is one poll of the
// tacho pin with its microsecond timestamp, and each poll yields one rpm
// item. The front end takes one poll per cycle while the queue has room and
// posts a command into a two-deep queue; polls that carry no accepted
// interval are retired by the back end straight from its idle state. A poll
// whose edge gives an accepted interval holds the back end while the
// bit-serial 25-bit divider is used twice in turn (sum over count, then
// 30000000 over the average) and the result is scaled and saturated before
// its rpm item is offered; meanwhile the front end keeps accepting polls until the queue fills.
// ----------------------------------------------------------------------------
// Tachometer rpm averager top level
// Configuration registers, front end, command queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tachometer_rpm_averager_unit #(
	parameter int SAMPLES = tacho_pkg::SAMPLES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tacho_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tacho_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            pin_level,
	input  wire logic [tacho_pkg::TIME_W-1:0]     now_us,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [tacho_pkg::RPM_W-1:0]           rpm_out
);
	import tacho_pkg::*;

	cfg_t    cfg_q;
	logic    push;
	cmd_t    push_cmd;
	logic    pop;
	cmd_t    head;
	q_stat_t q_stat;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mult    <= MULT_RST;
			cfg_q.min_iv  <= MIN_IV_RST;
			cfg_q.max_iv  <= MAX_IV_RST;
			cfg_q.timeout <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MULT:    cfg_q.mult    <= cfg_data[MULT_W-1:0];
				REG_MIN_IV:  cfg_q.min_iv  <= cfg_data[IV_W-1:0];
				REG_MAX_IV:  cfg_q.max_iv  <= cfg_data[IV_W-1:0];
				REG_TIMEOUT: cfg_q.timeout <= cfg_data[TIME_W-1:0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	tacho_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pin_level (pin_level),
		.now_us    (now_us),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	tacho_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	tacho_back #(
		.SAMPLES (SAMPLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mult      (cfg_q.mult),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rpm_out   (rpm_out)
	);

endmodule

`default_nettype wire

>>> hw/rtl/tacho_div.sv
// ----------------------------------------------------------------------------
// Tachometer rpm averager: bit-serial divider
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
`default_nettype none

module tacho_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire tacho_pkg::div_req_t      req,
	output logic                          done,
	output logic [tacho_pkg::DIV_W-1:0]   quo
);
	import tacho_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DIV_W:0]   rem_sh;
	logic [DIV_W:0]   diff;
	logic             qbit;

	// Trial subtract of the shifted partial remainder
	always_comb begin
		rem_sh = {rem_q, quo_q[DIV_W-1]};
		diff   = rem_sh - {1'b0, den_q};
		qbit   = ~diff[DIV_W];
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load operands, then shift one quotient bit in per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			rem_q <= qbit ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/tacho_front.sv
// ----------------------------------------------------------------------------
// Tachometer rpm averager: front end
// Takes polls, detects rising edges, measures and screens intervals, tracks
// the pulse timeout and posts one command per poll to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tacho_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tacho_pkg::cfg_t             cfg,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        pin_level,
	input  wire logic [tacho_pkg::TIME_W-1:0] now_us,
	input  wire tacho_pkg::q_stat_t          q_stat,
	output logic                             push,
	output tacho_pkg::cmd_t                  push_cmd
);
	import tacho_pkg::*;

	logic              prev_q;
	logic [TIME_W-1:0] last_q;
	logic              rising;
	logic              have_pulse;
	logic [TIME_W-1:0] elapsed;
	logic              iv_ok;
	logic              timed_out;

	assign in_ready = ~q_stat.full;
	assign push     = in_valid & ~q_stat.full;

	// Classify the poll; on an edge the elapsed time is the interval
	always_comb begin
		rising     = pin_level & ~prev_q;
		have_pulse = (last_q != '0);
		elapsed    = now_us - last_q;
		iv_ok      = rising && have_pulse
			&& (elapsed > TIME_W'(cfg.min_iv)) && (elapsed < TIME_W'(cfg.max_iv));
		timed_out  = ~rising && have_pulse && (elapsed > cfg.timeout);
		push_cmd.iv = elapsed[IV_W-1:0];
		if (iv_ok) begin
			push_cmd.kind = CMD_CALC;
		end else if (timed_out) begin
			push_cmd.kind = CMD_CLEAR;
		end else begin
			push_cmd.kind = CMD_HOLD;
		end
	end

	// Advance pin history and last pulse time on each item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			last_q <= '0;
		end else if (push) begin
			prev_q <= pin_level;
			if (rising) begin
				last_q <= now_us;
			end else if (timed_out) begin
				last_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tacho_queue.sv
// ----------------------------------------------------------------------------
// Tachometer rpm averager: command queue
// Short FIFO between front and back end so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tacho_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tacho_pkg::cmd_t    push_cmd,
	input  wire logic               pop,
	output tacho_pkg::cmd_t         head,
	output tacho_pkg::q_stat_t      stat
);
	import tacho_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	cmd_t             entry_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNT_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the incoming command
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tacho_back.sv
// ----------------------------------------------------------------------------
// Tachometer rpm averager: back end
// Keeps the interval ring and running sum, averages, converts to rpm on the
// shared divider, scales and saturates, and holds the result for output.
// ----------------------------------------------------------------------------
`default_nettype none

module tacho_back #(
	parameter int SAMPLES = tacho_pkg::SAMPLES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [tacho_pkg::MULT_W-1:0]  mult,
	input  wire tacho_pkg::cmd_t               head,
	input  wire tacho_pkg::q_stat_t            q_stat,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [tacho_pkg::RPM_W-1:0]        rpm_out
);
	import tacho_pkg::*;

	localparam int SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int CNT_W  = $clog2(SAMPLES + 1);
	localparam int SUM_W  = IV_W + $clog2(SAMPLES);
	localparam int PROD_W = DIV_W + MULT_W;

	back_state_t        state_q;
	back_state_t        state_d;
	logic [IV_W-1:0]    ring_q [SAMPLES];
	logic [SLOT_W-1:0]  slot_q;
	logic               full_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   count_q;
	logic [IV_W-1:0]    avg_q;
	logic [PROD_W-1:0]  prod_q;
	logic [RPM_W-1:0]   rpm_q;
	logic               out_valid_q;

	logic               out_free;
	logic               last_slot;
	logic               ring_wr;
	logic               load_out;
	logic               set_rpm;
	logic               clear_rpm;
	logic               take_avg;
	logic               take_prod;
	logic [RPM_W-1:0]   rpm_sat;
	div_req_t           div_req;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;

	tacho_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign out_free  = ~out_valid_q | out_ready;
	assign last_slot = (slot_q == SLOT_W'(SAMPLES - 1));
	assign rpm_sat   = (prod_q > PROD_W'(RPM_MAX)) ? RPM_MAX : prod_q[RPM_W-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_stat.empty && out_free && head.kind == CMD_CALC) begin
					state_d = B_AVG_GO;
				end
			end
			B_AVG_GO:   state_d = B_AVG_WAIT;
			B_AVG_WAIT: if (div_done) state_d = B_RPM_GO;
			B_RPM_GO:   state_d = B_RPM_WAIT;
			B_RPM_WAIT: if (div_done) state_d = B_SAT;
			B_SAT:      state_d = B_IDLE;
			default:    state_d = B_IDLE;
		endcase
	end

	// Control outputs of each state
	always_comb begin
		pop         = 1'b0;
		ring_wr     = 1'b0;
		load_out    = 1'b0;
		set_rpm     = 1'b0;
		clear_rpm   = 1'b0;
		take_avg    = 1'b0;
		take_prod   = 1'b0;
		div_req     = '0;
		case (state_q)
			B_IDLE: begin
				if (!q_stat.empty && out_free) begin
					pop = 1'b1;
					if (head.kind == CMD_CALC) begin
						ring_wr = 1'b1;
					end else begin
						load_out  = 1'b1;
						clear_rpm = (head.kind == CMD_CLEAR);
					end
				end
			end
			B_AVG_GO: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_W'(sum_q);
				div_req.den   = DIV_W'(count_q);
			end
			B_AVG_WAIT: take_avg = div_done;
			B_RPM_GO: begin
				div_req.start = 1'b1;
				div_req.num   = RPM_NUMER;
				div_req.den   = DIV_W'(avg_q);
			end
			B_RPM_WAIT: take_prod = div_done;
			B_SAT: begin
				load_out = 1'b1;
				set_rpm  = 1'b1;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// State, ring bookkeeping, rpm and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			slot_q      <= '0;
			full_q      <= 1'b0;
			sum_q       <= '0;
			rpm_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SAMPLES; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (ring_wr) begin
				ring_q[slot_q] <= head.iv;
				sum_q  <= sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(head.iv);
				slot_q <= last_slot ? '0 : slot_q + 1'b1;
				if (last_slot) begin
					full_q <= 1'b1;
				end
			end
			if (set_rpm) begin
				rpm_q <= rpm_sat;
			end else if (clear_rpm) begin
				rpm_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working values of the rpm calculation
	always_ff @(posedge clk) begin
		if (ring_wr) begin
			count_q <= (full_q || last_slot) ? CNT_W'(SAMPLES) : CNT_W'(slot_q) + 1'b1;
		end
		if (take_avg) begin
			avg_q <= (div_quo == '0) ? IV_W'(1) : div_quo[IV_W-1:0];
		end
		if (take_prod) begin
			prod_q <= PROD_W'(div_quo) * PROD_W'(mult);
		end
	end

	assign out_valid = out_valid_q;
	assign rpm_out   = rpm_q;

endmodule

`default_nettype wire

>>> hw/rtl/tacho_chk.sv
// ----------------------------------------------------------------------------
// Tachometer rpm averager: port checker
// Watches the result channel of the top level over time; bound below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tachometer_rpm_averager_unit_defines.svh"

module tacho_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [tacho_pkg::RPM_W-1:0]   rpm_out
);
	import tacho_pkg::*;

	// No result is offered once a reset edge has been seen
	`TACHO_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |=> !out_valid, "result offered in reset")

	// Rpm never passes the saturation limit
	`TACHO_ASSERT(a_rpm_limit, out_valid |-> (rpm_out <= RPM_MAX), "rpm above limit")

	// A stalled result stays offered
	`TACHO_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result dropped")

	// A stalled result keeps its value
	`TACHO_ASSERT(a_out_stable, (out_valid && !out_ready) |=> $stable(rpm_out), "rpm changed")

endmodule

bind tachometer_rpm_averager_unit tacho_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.rpm_out   (rpm_out)
);

`default_nettype wire

>>> bench/tacho_rpm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tachometer rpm averager scoreboard
// Watches the register port and both item channels. Keeps its own copy of the
// registers and of the pulse history, works out the rpm of every accepted
// poll and compares it with the rpm items that leave the block, in order.
// ----------------------------------------------------------------------------
module tacho_rpm_checker
	import tacho_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  pin_level,
	input  logic [TIME_W-1:0]     now_us,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [RPM_W-1:0]      rpm_out,
	output int                    faults,
	output int                    outstanding
);

	localparam int RING_N     = SAMPLES_DEF;
	localparam int REPORT_MAX = 10;

	// register copy
	logic [MULT_W-1:0] mult_q;
	logic [IV_W-1:0]   min_iv_q;
	logic [IV_W-1:0]   max_iv_q;
	logic [TIME_W-1:0] timeout_q;

	// pulse history copy
	logic              level_q;
	logic [TIME_W-1:0] last_pulse_q;
	logic [IV_W-1:0]   period_ring [RING_N];
	int unsigned       slot_q;
	logic              filled_q;
	logic [RPM_W-1:0]  rpm_q;

	// rpm values still owed by the block, oldest first
	logic [RPM_W-1:0]  rpm_due [$];
	logic [RPM_W-1:0]  rpm_want;
	int                fault_cnt;

	// Store an accepted period and recompute rpm from the ring average
	task automatic store_period(input logic [TIME_W-1:0] period);
		int unsigned       used;
		logic [31:0]       total;
		logic [31:0]       mean;
		logic [31:0]       quot;
		logic [63:0]       scaled;
		period_ring[slot_q] = period[IV_W-1:0];
		slot_q = (slot_q == RING_N - 1) ? 0 : slot_q + 1;
		if (slot_q == 0)
			filled_q = 1'b1;
		used = filled_q ? RING_N : slot_q;
		total = '0;
		for (int i = 0; i < used; i++)
			total += 32'(period_ring[i]);
		mean = total / used;
		if (mean == 0)
			mean = 1;
		quot = 32'(RPM_NUMER) / mean;
		scaled = 64'(quot) * 64'(mult_q);
		rpm_q = (scaled > 64'(RPM_MAX)) ? RPM_MAX : scaled[RPM_W-1:0];
	endtask

	// Advance the history by one poll
	task automatic track_poll(input logic level, input logic [TIME_W-1:0] stamp);
		logic [TIME_W-1:0] period;
		if (level && !level_q) begin
			if (last_pulse_q != '0) begin
				period = stamp - last_pulse_q;
				if (period > 32'(min_iv_q) && period < 32'(max_iv_q))
					store_period(period);
			end
			last_pulse_q = stamp;
		end
		level_q = level;
		// no pulse for too long: drop rpm and forget the pulse time
		if (last_pulse_q != '0 && TIME_W'(stamp - last_pulse_q) > timeout_q) begin
			rpm_q = '0;
			last_pulse_q = '0;
		end
	endtask

	function automatic bit fault_logged();
		fault_cnt++;
		return fault_cnt <= REPORT_MAX;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q = MULT_RST;
			min_iv_q = MIN_IV_RST;
			max_iv_q = MAX_IV_RST;
			timeout_q = TIMEOUT_RST;
			level_q = 1'b0;
			last_pulse_q = '0;
			for (int i = 0; i < RING_N; i++)
				period_ring[i] = '0;
			slot_q = 0;
			filled_q = 1'b0;
			rpm_q = '0;
			rpm_due.delete();
			fault_cnt = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_MULT:    mult_q = cfg_data[MULT_W-1:0];
					REG_MIN_IV:  min_iv_q = cfg_data[IV_W-1:0];
					REG_MAX_IV:  max_iv_q = cfg_data[IV_W-1:0];
					REG_TIMEOUT: timeout_q = cfg_data[TIME_W-1:0];
					default: ;
				endcase
			end
			// predict the rpm of an accepted poll
			if (in_valid && in_ready) begin
				track_poll(pin_level, now_us);
				rpm_due.push_back(rpm_q);
			end
			// compare a leaving rpm item with the oldest prediction
			if (out_valid && out_ready) begin
				if (rpm_due.size() == 0) begin
					if (fault_logged())
						$display("%0t: rpm item %0d with no poll pending", $time, rpm_out);
				end else begin
					rpm_want = rpm_due.pop_front();
					if (rpm_out !== rpm_want && fault_logged())
						$display("%0t: rpm_out expected %0d, got %0d",
							$time, rpm_want, rpm_out);
				end
			end
		end
		faults <= fault_cnt;
		outstanding <= rpm_due.size();
	end

endmodule

>>> bench/tb_tachometer_rpm_averager_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tachometer rpm averager testbench
// Drives polls of the tacho pin: a directed opening over the window limits,
// time zero, timeout, wrap and rpm saturation, then pulse trains, noise and
// long gaps under several register settings and idling patterns. A separate
// scoreboard predicts and checks every rpm item.
// ----------------------------------------------------------------------------
module tb_tachometer_rpm_averager_unit;
	import tacho_pkg::*;

	localparam int PHASE_POLLS = 275;
	localparam int CFG_SETS    = 7;
	localparam int TAIL_CYCLES = 64;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  pin_level;
	logic [TIME_W-1:0]     now_us;
	logic                  out_valid;
	logic                  out_ready;
	logic [RPM_W-1:0]      rpm_out;
	int                    faults;
	int                    outstanding;

	int unsigned           send_idle_pct;
	int unsigned           stall_pct;
	int unsigned           polls_sent;
	logic [31:0]           stamp;
	logic [31:0]           win_min;
	logic [31:0]           win_max;
	logic [31:0]           win_tmo;

	// register settings per phase; the sixth is drawn at random
	logic [31:0] set_mult [CFG_SETS] = '{15, 0, 8, 4, 1, 0, 2};
	logic [31:0] set_min  [CFG_SETS] = '{0, 1050, 262143, 500, 100, 0, 1050};
	logic [31:0] set_max  [CFG_SETS] = '{262143, 200000, 1, 3000, 101, 0, 200000};
	logic [31:0] set_tmo  [CFG_SETS] = '{32'hFFFF_FFFF, 1000000, 1, 20000, 50000, 0, 1000000};

	tachometer_rpm_averager_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pin_level (pin_level),
		.now_us    (now_us),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rpm_out   (rpm_out)
	);

	tacho_rpm_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pin_level   (pin_level),
		.now_us      (now_us),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rpm_out     (rpm_out),
		.faults      (faults),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Offer one poll and hold it until taken
	task automatic send_poll(input logic level, input logic [31:0] at_us);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pin_level <= level;
		now_us <= at_us;
		do @(posedge clk); while (!in_ready);
		polls_sent++;
	endtask

	// Drop valid and wait for every rpm item owed
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Rising edges at periods around the acceptance window
	task automatic pulse_train(input int pulses);
		logic [31:0] period;
		logic [31:0] low_at;
		for (int k = 0; k < pulses; k++) begin
			if (win_max > win_min + 1) begin
				case ($urandom_range(9))
					0: period = win_min;
					1: period = win_min + 1;
					2: period = win_max - 1;
					3: period = win_max;
					4: begin
						period = win_min + $urandom_range(1, 4);
						if (period >= win_max)
							period = win_max - 1;
					end
					default: period = $urandom_range(win_min + 1, win_max - 1);
				endcase
			end else begin
				period = $urandom_range(1, 262143);
			end
			low_at = stamp + $urandom_range(0, period);
			send_poll(1'b0, low_at);
			if ($urandom_range(3) == 0)
				send_poll(1'b0, low_at + (stamp + period - low_at) / 2);
			stamp = stamp + period;
			send_poll(1'b1, stamp);
			if ($urandom_range(3) == 0)
				send_poll(1'b1, stamp + 1);
		end
	endtask

	initial begin
		int unsigned phase_end;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pin_level = 1'b0;
		now_us = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		polls_sent = 0;
		stamp = '0;
		win_min = 32'(MIN_IV_RST);
		win_max = 32'(MAX_IV_RST);
		win_tmo = TIMEOUT_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// edge at time zero records no pulse; next edge takes no period
		send_poll(1'b1, 32'd0);
		send_poll(1'b0, 32'd10);
		send_poll(1'b1, 32'd5000);
		// period equal to the lower limit, then just above it
		send_poll(1'b0, 32'd5500);
		send_poll(1'b1, 32'd6050);
		send_poll(1'b0, 32'd6500);
		send_poll(1'b1, 32'd7101);
		send_poll(1'b1, 32'd7200);
		// just below the upper limit, then equal to it
		send_poll(1'b0, 32'd8000);
		send_poll(1'b1, 32'd207100);
		send_poll(1'b0, 32'd207200);
		send_poll(1'b1, 32'd407100);
		// gap equal to the timeout keeps rpm, one more clears it
		send_poll(1'b0, 32'd1407100);
		send_poll(1'b0, 32'd1407101);
		// period across the timestamp wrap
		send_poll(1'b1, 32'hFFFF_FF00);
		send_poll(1'b0, 32'hFFFF_FFFF);
		send_poll(1'b1, 32'h0000_1000);

		// ring full of one-microsecond periods saturates rpm
		drain();
		write_reg(REG_MULT, 32'd15);
		write_reg(REG_MIN_IV, 32'd0);
		write_reg(REG_MAX_IV, 32'd262143);
		stamp = 32'h0000_1000;
		repeat (5) begin
			send_poll(1'b0, stamp);
			stamp = stamp + 1;
			send_poll(1'b1, stamp);
		end
		// zero multiplier
		drain();
		write_reg(REG_MULT, 32'd0);
		send_poll(1'b0, stamp);
		stamp = stamp + 1;
		send_poll(1'b1, stamp);

		for (int s = 0; s < CFG_SETS; s++) begin
			drain();
			case (idle_mode_t'(s % 4))
				IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
				IDLE_SEND: begin send_idle_pct = 67; stall_pct = 0;  end
				IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 67; end
				default:   begin send_idle_pct = 24; stall_pct = 24; end
			endcase
			if (s == 5) begin
				set_mult[s] = $urandom_range(1, 8);
				set_min[s] = $urandom_range(0, 5000);
				set_max[s] = set_min[s] + $urandom_range(2, 60000);
				set_tmo[s] = $urandom_range(1, 3000000);
			end
			write_reg(REG_MULT, set_mult[s]);
			write_reg(REG_MIN_IV, set_min[s]);
			write_reg(REG_MAX_IV, set_max[s]);
			write_reg(REG_TIMEOUT, set_tmo[s]);
			win_min = set_min[s];
			win_max = set_max[s];
			win_tmo = set_tmo[s];

			phase_end = polls_sent + PHASE_POLLS;
			while (polls_sent < phase_end) begin
				case ($urandom_range(9))
					7: begin
						// silence around the timeout
						stamp = stamp + win_tmo + $urandom_range(0, 1);
						send_poll(1'($urandom_range(1)), stamp);
					end
					8: begin
						// noise: arbitrary levels and timestamps
						repeat ($urandom_range(1, 4)) begin
							stamp = $urandom;
							send_poll(1'($urandom_range(1)), stamp);
						end
					end
					9: begin
						if ($urandom_range(1) == 0) begin
							// run up to the wrap point
							stamp = 32'hFFFF_FFFF - $urandom_range(0, 2 * win_max);
						end else begin
							// edge at time zero
							send_poll(1'b0, stamp + 1);
							stamp = '0;
							send_poll(1'b1, stamp);
						end
					end
					default: pulse_train($urandom_range(1, 12));
				endcase
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (faults == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// hang guard
	initial begin
		#40_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/tacho_pkg.sv
hw/rtl/tacho_div.sv
hw/rtl/tacho_front.sv
hw/rtl/tacho_queue.sv
hw/rtl/tacho_back.sv
hw/rtl/tachometer_rpm_averager_unit.sv
hw/rtl/tacho_chk.sv
bench/tacho_rpm_checker.sv
bench/tb_tachometer_rpm_averager_unit.sv
